>>> hdl/dtol_pkg.sv
`timescale 1ns / 1ps
package dtol_pkg;

  localparam int DEF_MAX_NODES    = 32;
  localparam int DEF_MAX_EDGES    = 64;
  localparam int DEF_LATENCY_BITS = 16;

  localparam int ID_W  = 6;
  localparam int LAT_W = 22;
  localparam logic [LAT_W-1:0] LAT_SAT = 22'h3F_FFFF;

  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_CONNECT    = 3'd2,
    CMD_DISCONNECT = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_COMPILE    = 3'd5,
    CMD_QUERY_LAT  = 3'd6,
    CMD_QUERY_ORD  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_CYCLE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_WR,
    S_CONN_RD,
    S_CONN_CHK,
    S_CMP_CLR,
    S_CNT_RD,
    S_CNT_EDGE,
    S_CNT_INC,
    S_SEED_RD,
    S_SEED_CHK,
    S_BFS_HEAD,
    S_BFS_ID,
    S_BFS_RD,
    S_BFS_EDGE,
    S_BFS_DEC,
    S_LAT_HEAD,
    S_LAT_ID,
    S_LAT_RD,
    S_LAT_EDGE,
    S_LAT_CMP,
    S_LAT_SUM,
    S_Q_ORD,
    S_Q_LAT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   node_id;
    logic [LAT_W-1:0]  latency;
  } result_t;

endpackage

>>> hdl/dtol_edge_store.sv
`timescale 1ns / 1ps
module dtol_edge_store #(
  parameter int MAX_EDGES = dtol_pkg::DEF_MAX_EDGES,
  parameter int EAW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                      clk_i,
  input  dtol_pkg::mem_ctl_t        ctl_i,
  input  logic [EAW-1:0]            waddr_i,
  input  logic [dtol_pkg::ID_W-1:0] wsrc_i,
  input  logic [dtol_pkg::ID_W-1:0] wtgt_i,
  input  logic [EAW-1:0]            raddr_i,
  output logic [dtol_pkg::ID_W-1:0] rsrc_o,
  output logic [dtol_pkg::ID_W-1:0] rtgt_o
);

  logic [2*dtol_pkg::ID_W-1:0] mem [MAX_EDGES];
  logic [2*dtol_pkg::ID_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= {wtgt_i, wsrc_i};
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rsrc_o = rd_q[dtol_pkg::ID_W-1:0];
  assign rtgt_o = rd_q[2*dtol_pkg::ID_W-1:dtol_pkg::ID_W];

endmodule

>>> hdl/dtol_ctrl.sv
`timescale 1ns / 1ps
module dtol_ctrl #(
  parameter int MAX_NODES    = dtol_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES    = dtol_pkg::DEF_MAX_EDGES,
  parameter int LATENCY_BITS = dtol_pkg::DEF_LATENCY_BITS,
  parameter int EAW          = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dtol_pkg::cmd_e            in_cmd_i,
  input  logic [dtol_pkg::ID_W-1:0] in_a_i,
  input  logic [dtol_pkg::ID_W-1:0] in_b_i,
  input  logic [15:0]               in_lat_i,
  input  logic [4:0]                in_pos_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output dtol_pkg::result_t         res_o,
  output dtol_pkg::mem_ctl_t        e_ctl_o,
  output logic [EAW-1:0]            e_waddr_o,
  output logic [dtol_pkg::ID_W-1:0] e_wsrc_o,
  output logic [dtol_pkg::ID_W-1:0] e_wtgt_o,
  output logic [EAW-1:0]            e_raddr_o,
  input  logic [dtol_pkg::ID_W-1:0] e_src_i,
  input  logic [dtol_pkg::ID_W-1:0] e_tgt_i
);

  localparam int ID_W  = dtol_pkg::ID_W;
  localparam int LAT_W = dtol_pkg::LAT_W;
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int NIDX  = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int SUM_W = ((LATENCY_BITS > LAT_W) ? LATENCY_BITS : LAT_W) + 1;

  dtol_pkg::state_e st_q, st_d;

  dtol_pkg::cmd_e    cmd_q;
  logic [ID_W-1:0]   a_q, b_q;
  logic [15:0]       lat_q;
  logic [4:0]        pos_q;

  logic [MAX_NODES-1:0] present_q, present_d;
  logic [ID_W-1:0]      next_id_q, next_id_d;
  logic [EW-1:0]        edge_cnt_q, edge_cnt_d;
  logic [NW-1:0]        order_len_q, order_len_d;
  logic [LAT_W-1:0]     largest_q, largest_d;
  logic                 compiled_q, compiled_d;

  logic [EW-1:0]     idx_q, idx_d, wix_q, wix_d;
  logic              found_q, found_d;
  logic [NW-1:0]     node_q, node_d, head_q, head_d, tail_q, tail_d, n_q, n_d;
  logic [ID_W-1:0]   cur_q, cur_d, tgt_q, tgt_d;
  logic [LAT_W-1:0]  best_q, best_d;
  dtol_pkg::result_t res_q, res_d;

  // node-indexed memories
  logic [LATENCY_BITS-1:0] own_mem [MAX_NODES];
  logic [LAT_W-1:0]        path_mem [MAX_NODES];
  logic [NW-1:0]           deg_mem [MAX_NODES];
  logic [ID_W-1:0]         ord_mem [MAX_NODES];

  logic                    own_we, own_re, path_we, path_re;
  logic                    deg_we, deg_re, ord_we, ord_re;
  logic [NIDX-1:0]         own_wa, own_ra, path_wa, path_ra;
  logic [NIDX-1:0]         deg_wa, deg_ra, ord_wa, ord_ra;
  logic [LATENCY_BITS-1:0] own_wd, own_rd_q;
  logic [LAT_W-1:0]        path_wd, path_rd_q;
  logic [NW-1:0]           deg_wd, deg_rd_q;
  logic [ID_W-1:0]         ord_wd, ord_rd_q;

  function automatic logic [NIDX-1:0] to_ix(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] m;
    m = id - 1'b1;
    return NIDX'(m);
  endfunction

  function automatic logic id_ok(input logic [ID_W-1:0] id,
                                 input logic [MAX_NODES-1:0] pres);
    return (id != '0) && (id <= ID_W'(MAX_NODES)) && pres[to_ix(id)];
  endfunction

  logic e_more, head_more, ok_a, conn_bad, ord_ok, scan_hit, dup;
  logic node_last, seed_done, tgt_ok, src_ok;
  logic [SUM_W-1:0] sum;
  logic [LAT_W-1:0] sat;

  assign e_more    = idx_q < edge_cnt_q;
  assign head_more = head_q < tail_q;
  assign ok_a      = id_ok(a_q, present_q);
  assign conn_bad  = (a_q == '0) || (b_q == '0) || (a_q == b_q) || !ok_a
                   || !id_ok(b_q, present_q) || (edge_cnt_q >= EW'(MAX_EDGES));
  assign ord_ok    = compiled_q && (7'(pos_q) < 7'(order_len_q));
  assign scan_hit  = (cmd_q == dtol_pkg::CMD_REMOVE)
                   ? ((e_src_i == a_q) || (e_tgt_i == a_q))
                   : ((e_src_i == a_q) && (e_tgt_i == b_q));
  assign dup       = (e_src_i == a_q) && (e_tgt_i == b_q);
  assign node_last = node_q == NW'(MAX_NODES - 1);
  assign seed_done = node_q == NW'(MAX_NODES);
  assign tgt_ok    = id_ok(e_tgt_i, present_q);
  assign src_ok    = id_ok(e_src_i, present_q);
  assign sum       = SUM_W'(best_q) + SUM_W'(own_rd_q);
  assign sat       = (sum > SUM_W'(dtol_pkg::LAT_SAT)) ? dtol_pkg::LAT_SAT : LAT_W'(sum);

  assign in_ready_o  = st_q == dtol_pkg::S_IDLE;
  assign res_valid_o = st_q == dtol_pkg::S_DONE;
  assign res_o       = res_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dtol_pkg::S_IDLE: if (in_valid_i) st_d = dtol_pkg::S_DISPATCH;
      dtol_pkg::S_DISPATCH: begin
        unique case (cmd_q)
          dtol_pkg::CMD_ADD, dtol_pkg::CMD_CLEAR: st_d = dtol_pkg::S_DONE;
          dtol_pkg::CMD_REMOVE:
            st_d = ok_a ? dtol_pkg::S_SCAN_RD : dtol_pkg::S_DONE;
          dtol_pkg::CMD_DISCONNECT: st_d = dtol_pkg::S_SCAN_RD;
          dtol_pkg::CMD_CONNECT:
            st_d = conn_bad ? dtol_pkg::S_DONE : dtol_pkg::S_CONN_RD;
          dtol_pkg::CMD_COMPILE: st_d = dtol_pkg::S_CMP_CLR;
          dtol_pkg::CMD_QUERY_LAT:
            st_d = (compiled_q && ok_a) ? dtol_pkg::S_Q_LAT : dtol_pkg::S_DONE;
          dtol_pkg::CMD_QUERY_ORD:
            st_d = ord_ok ? dtol_pkg::S_Q_ORD : dtol_pkg::S_DONE;
          default: st_d = dtol_pkg::S_DONE;
        endcase
      end
      dtol_pkg::S_SCAN_RD:  st_d = e_more ? dtol_pkg::S_SCAN_WR : dtol_pkg::S_DONE;
      dtol_pkg::S_SCAN_WR:  st_d = dtol_pkg::S_SCAN_RD;
      dtol_pkg::S_CONN_RD:  st_d = e_more ? dtol_pkg::S_CONN_CHK : dtol_pkg::S_DONE;
      dtol_pkg::S_CONN_CHK: st_d = dup ? dtol_pkg::S_DONE : dtol_pkg::S_CONN_RD;
      dtol_pkg::S_CMP_CLR:  st_d = node_last ? dtol_pkg::S_CNT_RD : dtol_pkg::S_CMP_CLR;
      dtol_pkg::S_CNT_RD:   st_d = e_more ? dtol_pkg::S_CNT_EDGE : dtol_pkg::S_SEED_RD;
      dtol_pkg::S_CNT_EDGE: st_d = tgt_ok ? dtol_pkg::S_CNT_INC : dtol_pkg::S_CNT_RD;
      dtol_pkg::S_CNT_INC:  st_d = dtol_pkg::S_CNT_RD;
      dtol_pkg::S_SEED_RD:  st_d = seed_done ? dtol_pkg::S_BFS_HEAD : dtol_pkg::S_SEED_CHK;
      dtol_pkg::S_SEED_CHK: st_d = dtol_pkg::S_SEED_RD;
      dtol_pkg::S_BFS_HEAD: begin
        if (head_more) st_d = dtol_pkg::S_BFS_ID;
        else if (tail_q == n_q) st_d = dtol_pkg::S_LAT_HEAD;
        else st_d = dtol_pkg::S_DONE;
      end
      dtol_pkg::S_BFS_ID:   st_d = dtol_pkg::S_BFS_RD;
      dtol_pkg::S_BFS_RD:   st_d = e_more ? dtol_pkg::S_BFS_EDGE : dtol_pkg::S_BFS_HEAD;
      dtol_pkg::S_BFS_EDGE:
        st_d = ((e_src_i == cur_q) && tgt_ok) ? dtol_pkg::S_BFS_DEC : dtol_pkg::S_BFS_RD;
      dtol_pkg::S_BFS_DEC:  st_d = dtol_pkg::S_BFS_RD;
      dtol_pkg::S_LAT_HEAD: st_d = head_more ? dtol_pkg::S_LAT_ID : dtol_pkg::S_DONE;
      dtol_pkg::S_LAT_ID:   st_d = dtol_pkg::S_LAT_RD;
      dtol_pkg::S_LAT_RD:   st_d = e_more ? dtol_pkg::S_LAT_EDGE : dtol_pkg::S_LAT_SUM;
      dtol_pkg::S_LAT_EDGE:
        st_d = ((e_tgt_i == cur_q) && src_ok) ? dtol_pkg::S_LAT_CMP : dtol_pkg::S_LAT_RD;
      dtol_pkg::S_LAT_CMP:  st_d = dtol_pkg::S_LAT_RD;
      dtol_pkg::S_LAT_SUM:  st_d = dtol_pkg::S_LAT_HEAD;
      dtol_pkg::S_Q_ORD:    st_d = dtol_pkg::S_Q_LAT;
      dtol_pkg::S_Q_LAT:    st_d = dtol_pkg::S_DONE;
      dtol_pkg::S_DONE:     if (res_ready_i) st_d = dtol_pkg::S_IDLE;
      default:              st_d = dtol_pkg::S_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    present_d   = present_q;
    next_id_d   = next_id_q;
    edge_cnt_d  = edge_cnt_q;
    order_len_d = order_len_q;
    largest_d   = largest_q;
    compiled_d  = compiled_q;
    idx_d       = idx_q;
    wix_d       = wix_q;
    found_d     = found_q;
    node_d      = node_q;
    head_d      = head_q;
    tail_d      = tail_q;
    n_d         = n_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    best_d      = best_q;
    res_d       = res_q;
    e_ctl_o     = '0;
    e_waddr_o   = EAW'(wix_q);
    e_wsrc_o    = e_src_i;
    e_wtgt_o    = e_tgt_i;
    e_raddr_o   = EAW'(idx_q);
    own_we = 1'b0; own_re = 1'b0; own_wa = to_ix(next_id_q); own_ra = to_ix(cur_q);
    own_wd = LATENCY_BITS'(lat_q);
    path_we = 1'b0; path_re = 1'b0; path_wa = to_ix(cur_q); path_ra = to_ix(e_src_i);
    path_wd = sat;
    deg_we = 1'b0; deg_re = 1'b0; deg_wa = to_ix(tgt_q); deg_ra = to_ix(e_tgt_i);
    deg_wd = '0;
    ord_we = 1'b0; ord_re = 1'b0; ord_wa = NIDX'(tail_q); ord_ra = NIDX'(head_q);
    ord_wd = tgt_q;

    unique case (st_q)
      dtol_pkg::S_DISPATCH: begin
        res_d = '{status: dtol_pkg::ST_OK, node_id: '0, latency: '0};
        idx_d   = '0;
        wix_d   = '0;
        found_d = 1'b0;
        unique case (cmd_q)
          dtol_pkg::CMD_ADD: begin
            if (next_id_q > ID_W'(MAX_NODES)) begin
              res_d.status = dtol_pkg::ST_REJECTED;
            end else begin
              own_we                    = 1'b1;
              present_d[to_ix(next_id_q)] = 1'b1;
              next_id_d                 = next_id_q + 1'b1;
              res_d.node_id             = next_id_q;
              order_len_d = '0; largest_d = '0; compiled_d = 1'b0;
            end
          end
          dtol_pkg::CMD_REMOVE: begin
            if (ok_a) present_d[to_ix(a_q)] = 1'b0;
            else res_d.status = dtol_pkg::ST_NOT_FOUND;
          end
          dtol_pkg::CMD_DISCONNECT: ;
          dtol_pkg::CMD_CONNECT: begin
            if (conn_bad) res_d.status = dtol_pkg::ST_REJECTED;
          end
          dtol_pkg::CMD_CLEAR: begin
            present_d  = '0;
            edge_cnt_d = '0;
            next_id_d  = ID_W'(1);
            order_len_d = '0; largest_d = '0; compiled_d = 1'b0;
          end
          dtol_pkg::CMD_COMPILE: begin
            order_len_d = '0; largest_d = '0; compiled_d = 1'b0;
            node_d = '0;
          end
          dtol_pkg::CMD_QUERY_LAT: begin
            cur_d = '0;
            if (compiled_q && ok_a) begin
              path_re = 1'b1;
              path_ra = to_ix(a_q);
            end else begin
              res_d.status = dtol_pkg::ST_NOT_FOUND;
            end
          end
          dtol_pkg::CMD_QUERY_ORD: begin
            if (ord_ok) begin
              ord_re = 1'b1;
              ord_ra = NIDX'(pos_q);
            end else begin
              res_d.status = dtol_pkg::ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      dtol_pkg::S_SCAN_RD: begin
        if (e_more) begin
          e_ctl_o.rd_en = 1'b1;
        end else begin
          edge_cnt_d = wix_q;
          if ((cmd_q == dtol_pkg::CMD_REMOVE) || found_q) begin
            order_len_d = '0; largest_d = '0; compiled_d = 1'b0;
          end else begin
            res_d.status = dtol_pkg::ST_NOT_FOUND;
          end
        end
      end
      dtol_pkg::S_SCAN_WR: begin
        // keep survivors packed in order
        if (scan_hit) begin
          found_d = 1'b1;
        end else begin
          e_ctl_o.wr_en = 1'b1;
          wix_d = wix_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      dtol_pkg::S_CONN_RD: begin
        if (e_more) begin
          e_ctl_o.rd_en = 1'b1;
        end else begin
          e_ctl_o.wr_en = 1'b1;
          e_waddr_o  = EAW'(edge_cnt_q);
          e_wsrc_o   = a_q;
          e_wtgt_o   = b_q;
          edge_cnt_d = edge_cnt_q + 1'b1;
          order_len_d = '0; largest_d = '0; compiled_d = 1'b0;
        end
      end
      dtol_pkg::S_CONN_CHK: begin
        if (dup) res_d.status = dtol_pkg::ST_REJECTED;
        else idx_d = idx_q + 1'b1;
      end
      dtol_pkg::S_CMP_CLR: begin
        deg_we = 1'b1;
        deg_wa = NIDX'(node_q);
        deg_wd = '0;
        node_d = node_q + 1'b1;
        idx_d  = '0;
      end
      dtol_pkg::S_CNT_RD: begin
        if (e_more) begin
          e_ctl_o.rd_en = 1'b1;
        end else begin
          node_d = '0;
          tail_d = '0;
          n_d    = '0;
        end
      end
      dtol_pkg::S_CNT_EDGE: begin
        if (tgt_ok) begin
          deg_re = 1'b1;
          tgt_d  = e_tgt_i;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      dtol_pkg::S_CNT_INC: begin
        deg_we = 1'b1;
        deg_wd = deg_rd_q + 1'b1;
        idx_d  = idx_q + 1'b1;
      end
      dtol_pkg::S_SEED_RD: begin
        if (seed_done) begin
          head_d = '0;
        end else begin
          deg_re = 1'b1;
          deg_ra = NIDX'(node_q);
        end
      end
      dtol_pkg::S_SEED_CHK: begin
        if (present_q[NIDX'(node_q)]) begin
          n_d = n_q + 1'b1;
          if (deg_rd_q == '0) begin
            ord_we = 1'b1;
            ord_wd = ID_W'(node_q) + 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        node_d = node_q + 1'b1;
      end
      dtol_pkg::S_BFS_HEAD: begin
        if (head_more) begin
          ord_re = 1'b1;
        end else if (tail_q == n_q) begin
          head_d    = '0;
          largest_d = '0;
        end else begin
          res_d.status = dtol_pkg::ST_CYCLE;
        end
      end
      dtol_pkg::S_BFS_ID: begin
        cur_d  = ord_rd_q;
        head_d = head_q + 1'b1;
        idx_d  = '0;
      end
      dtol_pkg::S_BFS_RD: begin
        if (e_more) e_ctl_o.rd_en = 1'b1;
      end
      dtol_pkg::S_BFS_EDGE: begin
        if ((e_src_i == cur_q) && tgt_ok) begin
          deg_re = 1'b1;
          tgt_d  = e_tgt_i;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      dtol_pkg::S_BFS_DEC: begin
        if (deg_rd_q != '0) begin
          deg_we = 1'b1;
          deg_wd = deg_rd_q - 1'b1;
          if ((deg_rd_q == NW'(1)) && (tail_q < NW'(MAX_NODES))) begin
            ord_we = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        idx_d = idx_q + 1'b1;
      end
      dtol_pkg::S_LAT_HEAD: begin
        if (head_more) begin
          ord_re = 1'b1;
        end else begin
          order_len_d   = tail_q;
          compiled_d    = 1'b1;
          res_d.latency = largest_q;
        end
      end
      dtol_pkg::S_LAT_ID: begin
        cur_d  = ord_rd_q;
        head_d = head_q + 1'b1;
        best_d = '0;
        idx_d  = '0;
      end
      dtol_pkg::S_LAT_RD: begin
        if (e_more) e_ctl_o.rd_en = 1'b1;
        else own_re = 1'b1;
      end
      dtol_pkg::S_LAT_EDGE: begin
        if ((e_tgt_i == cur_q) && src_ok) path_re = 1'b1;
        else idx_d = idx_q + 1'b1;
      end
      dtol_pkg::S_LAT_CMP: begin
        if (path_rd_q > best_q) best_d = path_rd_q;
        idx_d = idx_q + 1'b1;
      end
      dtol_pkg::S_LAT_SUM: begin
        path_we = 1'b1;
        if (sat > largest_q) largest_d = sat;
      end
      dtol_pkg::S_Q_ORD: begin
        cur_d   = ord_rd_q;
        path_re = 1'b1;
        path_ra = to_ix(ord_rd_q);
      end
      dtol_pkg::S_Q_LAT: begin
        res_d.latency = path_rd_q;
        res_d.node_id = cur_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= dtol_pkg::S_IDLE;
      present_q   <= '0;
      next_id_q   <= ID_W'(1);
      edge_cnt_q  <= '0;
      order_len_q <= '0;
      largest_q   <= '0;
      compiled_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      present_q   <= present_d;
      next_id_q   <= next_id_d;
      edge_cnt_q  <= edge_cnt_d;
      order_len_q <= order_len_d;
      largest_q   <= largest_d;
      compiled_q  <= compiled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && (st_q == dtol_pkg::S_IDLE)) begin
      cmd_q <= in_cmd_i;
      a_q   <= in_a_i;
      b_q   <= in_b_i;
      lat_q <= in_lat_i;
      pos_q <= in_pos_i;
    end
    idx_q   <= idx_d;
    wix_q   <= wix_d;
    found_q <= found_d;
    node_q  <= node_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    n_q     <= n_d;
    cur_q   <= cur_d;
    tgt_q   <= tgt_d;
    best_q  <= best_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[own_wa] <= own_wd;
    if (own_re) own_rd_q <= own_mem[own_ra];
    if (path_we) path_mem[path_wa] <= path_wd;
    if (path_re) path_rd_q <= path_mem[path_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (deg_re) deg_rd_q <= deg_mem[deg_ra];
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd_q <= ord_mem[ord_ra];
  end

  a_edge_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= EW'(MAX_EDGES))
    else $error("edge count past table size");

  a_next_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != '0) && (next_id_q <= ID_W'(MAX_NODES + 1)))
    else $error("next id out of range");

  a_cycle_uncompiled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == dtol_pkg::S_DONE) && (res_q.status == dtol_pkg::ST_CYCLE) |-> !compiled_q)
    else $error("cycle reported while compiled");

  a_order_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compiled_q |-> (order_len_q <= NW'(MAX_NODES)))
    else $error("order length past node count");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == dtol_pkg::S_IDLE) && in_valid_i |=> (st_q == dtol_pkg::S_DISPATCH))
    else $error("request accepted without dispatch");

endmodule

>>> hdl/dag_topological_order_latency.sv
`timescale 1ns / 1ps
// channel dir bits fields, low bit up
// s_axis in  40  command[2:0] first_id[8:3] second_id[14:9] node_latency[30:15] order_position[35:31]
// m_axis out 32  status[1:0] node_id[7:2] latency_value[29:8]
//
// One request at a time. Connect, remove and disconnect scan the edge table once;
// compile walks it once to count in-degrees, then once per node in each of the
// ordering and latency passes, with the edge table giving one read per cycle.
// Reset is immediate, no clearing pass. A held result lets one more request run, then stalls s_axis.
module dag_topological_order_latency #(
  parameter int MAX_NODES    = dtol_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES    = dtol_pkg::DEF_MAX_EDGES,
  parameter int LATENCY_BITS = dtol_pkg::DEF_LATENCY_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command, first_id, second_id, node_latency, order_position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status, node_id, latency_value
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  dtol_pkg::mem_ctl_t        e_ctl;
  logic [EAW-1:0]            e_waddr, e_raddr;
  logic [dtol_pkg::ID_W-1:0] e_wsrc, e_wtgt, e_src, e_tgt;
  logic                      res_valid, res_ready;
  dtol_pkg::result_t         res, out_q;
  logic                      out_valid_q;

  dtol_edge_store #(.MAX_EDGES(MAX_EDGES), .EAW(EAW)) u_edges (
    .clk_i   (clk_i),
    .ctl_i   (e_ctl),
    .waddr_i (e_waddr),
    .wsrc_i  (e_wsrc),
    .wtgt_i  (e_wtgt),
    .raddr_i (e_raddr),
    .rsrc_o  (e_src),
    .rtgt_o  (e_tgt)
  );

  dtol_ctrl #(
    .MAX_NODES    (MAX_NODES),
    .MAX_EDGES    (MAX_EDGES),
    .LATENCY_BITS (LATENCY_BITS),
    .EAW          (EAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (dtol_pkg::cmd_e'(s_axis_tdata[2:0])),
    .in_a_i      (s_axis_tdata[8:3]),
    .in_b_i      (s_axis_tdata[14:9]),
    .in_lat_i    (s_axis_tdata[30:15]),
    .in_pos_i    (s_axis_tdata[35:31]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .e_ctl_o     (e_ctl),
    .e_waddr_o   (e_waddr),
    .e_wsrc_o    (e_wsrc),
    .e_wtgt_o    (e_wtgt),
    .e_raddr_o   (e_raddr),
    .e_src_i     (e_src),
    .e_tgt_i     (e_tgt)
  );

  // load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.latency, out_q.node_id, out_q.status};

endmodule
